// ===== rtl/core/nearest_palette_color_match_defines.svh =====
// Assertion macros shared by the palette matcher RTL.
// Used by files that carry concurrent checks; depends on nothing else.
`ifndef NEAREST_PALETTE_COLOR_MATCH_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_MATCH_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define NPCM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("npcm check failed");

// Next-cycle implication, disabled during reset.
`define NPCM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("npcm check failed");

`endif

// ===== rtl/core/npcm_pkg.sv =====
// Package for the nearest palette color matcher.
// Holds the controller state type, hue unit result struct and fixed constants.
`timescale 1ns / 1ps

package npcm_pkg;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HUE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        done;
      logic [14:0] hue;
      logic [7:0]  delta;
   } hue_result_type;

   // Hue in 1/64 degree units.
   localparam logic [15:0] HUE_FULL     = 16'd23040;
   localparam logic [14:0] HUE_HALF     = 15'd11520;
   localparam logic [14:0] HUE_BASE_GRN = 15'd7680;
   localparam logic [14:0] HUE_BASE_BLU = 15'd15360;
   localparam logic [3:0]  DIV_STEPS    = 4'd11;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_TOLERANCE = 2'd0;
   localparam logic [1:0] REG_MODE      = 2'd1;
   localparam logic [1:0] REG_ACHROM    = 2'd2;

   localparam logic [9:0] TOL_RESET    = 10'd32;
   localparam logic [7:0] ACHROM_RESET = 8'd3;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_MATCH = 1'b1;

endpackage

// ===== rtl/core/npcm_hue.sv =====
// Hue unit: max/min sector select and a bit-serial restoring divider.
// Depends on npcm_pkg for the result struct and hue constants.
`timescale 1ns / 1ps

module npcm_hue import npcm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [7:0]     red,
   input  logic [7:0]     green,
   input  logic [7:0]     blue,
   output hue_result_type result
);

   logic [7:0]  mx, mn, p, n, diff;
   logic [14:0] base;
   logic        neg;
   logic [19:0] num;

   logic        run_ff, fin_ff, done_ff;
   logic [3:0]  step_ff;
   logic [19:0] rem_ff;
   logic [11:0] quo_ff;
   logic [7:0]  div_ff;
   logic [14:0] base_ff;
   logic        neg_ff;
   logic [14:0] hue_ff;

   logic [19:0] shifted;
   logic        ge;
   logic [15:0] hsum, hwrap;

   always_comb begin
      mx = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      mn = red;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      if (mx == red) begin
         base = 15'd0;
         p    = green;
         n    = blue;
      end else if (mx == green) begin
         base = HUE_BASE_GRN;
         p    = blue;
         n    = red;
      end else begin
         base = HUE_BASE_BLU;
         p    = red;
         n    = green;
      end
      neg  = (p < n);
      diff = neg ? (n - p) : (p - n);
      // 3840 * diff as 4096 * diff - 256 * diff.
      num  = {diff, 12'b0} - {4'b0, diff, 8'b0};
   end

   // The quotient never exceeds 3840, so twelve restoring steps suffice.
   assign shifted = {12'b0, div_ff} << step_ff;
   assign ge      = (rem_ff >= shifted);

   always_comb begin
      if (neg_ff) begin
         hsum = {1'b0, base_ff} + HUE_FULL - {4'b0, quo_ff};
      end else begin
         hsum = {1'b0, base_ff} + {4'b0, quo_ff};
      end
      hwrap = (hsum >= HUE_FULL) ? (hsum - HUE_FULL) : hsum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= fin_ff;
         fin_ff  <= run_ff && (step_ff == 4'd0);
         run_ff  <= start || (run_ff && (step_ff != 4'd0));
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= num;
         quo_ff  <= 12'd0;
         div_ff  <= mx - mn;
         base_ff <= base;
         neg_ff  <= neg;
         step_ff <= DIV_STEPS;
      end else if (run_ff) begin
         if (ge) rem_ff <= rem_ff - shifted;
         quo_ff[step_ff] <= ge;
         step_ff <= step_ff - 4'd1;
      end
      if (fin_ff) hue_ff <= hwrap[14:0];
   end

   assign result.done  = done_ff;
   assign result.hue   = hue_ff;
   assign result.delta = div_ff;

endmodule

// ===== rtl/core/nearest_palette_color_match.sv =====
// Top level of the nearest palette color matcher: controller, palette memory, scan pipe.
// Depends on npcm_pkg, npcm_hue and the assertion macro header.
//
// Usage: a request is taken when start is high and busy is low. A write request
// (kind 0) loads one palette slot with its color and enabled mark; a slot index
// at or beyond ENTRIES is dropped. A match request (kind 1) returns one result,
// marked by rsp_valid for a single cycle; the receiver cannot stall it.
// Each request first runs the hue unit, a one-bit-per-cycle divider of twelve
// steps. A write then stores the color with its hue and chroma span and busy
// drops. A match then reads the palette memory one entry per cycle, a rate
// set by the single memory read port, through a three-stage
// read/distance/compare pipe. Storing each entry's hue at write time keeps
// the divider off the scan path.
// After reset the block sweeps the palette memory, clearing one entry per
// cycle with busy high; configuration writes over the APB port are taken at
// any time and should be made while the block is idle.
`timescale 1ns / 1ps
`include "nearest_palette_color_match_defines.svh"

module nearest_palette_color_match import npcm_pkg::*; #(
   parameter int ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [5:0]  req_entry_index,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic        req_entry_enabled,
   output logic        rsp_valid,
   output logic        rsp_match_found,
   output logic [5:0]  rsp_match_index,
   output logic [9:0]  rsp_match_distance,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int MEM_W = 48;

   // Configuration registers.
   logic [9:0] tolerance_ff;
   logic       mode_ff;
   logic [7:0] achrom_ff;
   logic       cfg_we;

   assign pready = 1'b1;
   assign cfg_we = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= TOL_RESET;
         mode_ff      <= 1'b0;
         achrom_ff    <= ACHROM_RESET;
      end else if (cfg_we) begin
         case (paddr[3:2])
            REG_TOLERANCE: tolerance_ff <= pwdata[9:0];
            REG_MODE:      mode_ff      <= pwdata[0];
            REG_ACHROM:    achrom_ff    <= pwdata[7:0];
            default:       ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_TOLERANCE: prdata = {22'b0, tolerance_ff};
         REG_MODE:      prdata = {31'b0, mode_ff};
         REG_ACHROM:    prdata = {24'b0, achrom_ff};
         default:       prdata = 32'b0;
      endcase
   end

   // Request capture and hue unit.
   state_type      state_ff, state_in;
   logic           accept;
   logic           kind_ff, en_ff;
   logic [10:0]    slot_ff;
   logic [7:0]     red_ff, green_ff, blue_ff;
   hue_result_type hue_res;
   logic [14:0]    pix_hue_ff;
   logic           pix_chroma_ff;

   assign accept = start && !busy;

   npcm_hue u_hue (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .red    (req_red),
      .green  (req_green),
      .blue   (req_blue),
      .result (hue_res)
   );

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_kind;
         en_ff    <= req_entry_enabled;
         slot_ff  <= 11'(req_entry_index);
         red_ff   <= req_red;
         green_ff <= req_green;
         blue_ff  <= req_blue;
      end
      if (hue_res.done) begin
         pix_hue_ff    <= hue_res.hue;
         pix_chroma_ff <= (hue_res.delta != 8'd0) && (hue_res.delta >= achrom_ff);
      end
   end

   // Palette memory: {enabled, red, green, blue, chroma span, hue}.
   logic [MEM_W-1:0] pal_mem [ENTRIES];
   logic [MEM_W-1:0] mem_q_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [MEM_W-1:0] mem_wdata;
   logic             rd_issue;
   logic [CNT_W-1:0] cnt_ff;
   logic             cnt_end;
   logic             slot_ok;
   logic             clearing, write_now;

   assign cnt_end = (cnt_ff == CNT_W'(ENTRIES));
   assign slot_ok = (slot_ff < 11'(ENTRIES));

   always_comb begin
      if (clearing) begin
         mem_we    = 1'b1;
         mem_waddr = cnt_ff[IDX_W-1:0];
         mem_wdata = '0;
      end else begin
         mem_we    = write_now && slot_ok;
         mem_waddr = slot_ff[IDX_W-1:0];
         mem_wdata = {en_ff, red_ff, green_ff, blue_ff, hue_res.delta, hue_res.hue};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) pal_mem[mem_waddr] <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      if (rd_issue) mem_q_ff <= pal_mem[cnt_ff[IDX_W-1:0]];
   end

   logic rv_ff, dv_ff;

   // Controller: next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (cnt_ff == CNT_W'(ENTRIES - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (accept) state_in = ST_HUE;
         ST_HUE: begin
            if (hue_res.done) state_in = (kind_ff == KIND_MATCH) ? ST_SCAN : ST_IDLE;
         end
         ST_SCAN:  if (cnt_end && !rv_ff && !dv_ff) state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Controller: outputs.
   always_comb begin
      busy      = 1'b1;
      rsp_valid = 1'b0;
      clearing  = 1'b0;
      write_now = 1'b0;
      rd_issue  = 1'b0;
      case (state_ff)
         ST_CLEAR: clearing = 1'b1;
         ST_IDLE:  busy = 1'b0;
         ST_HUE:   write_now = hue_res.done && (kind_ff == KIND_WRITE);
         ST_SCAN:  rd_issue = !cnt_end;
         ST_DONE:  rsp_valid = 1'b1;
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (clearing || rd_issue) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end else if (state_ff == ST_HUE) begin
            cnt_ff <= '0;
         end
      end
   end

   // Scan pipe: read, distance, compare.
   logic [IDX_W-1:0] ridx_ff, didx_ff, best_idx_ff;
   logic [9:0]       dist_ff, best_dist_ff, scan_dist;
   logic             den_ff, found_ff;
   logic [7:0]       e_red, e_green, e_blue, e_delta;
   logic [14:0]      e_hue, hd;
   logic             e_en, e_chroma, use_hue;
   logic [9:0]       manh;

   assign e_en     = mem_q_ff[47];
   assign e_red    = mem_q_ff[46:39];
   assign e_green  = mem_q_ff[38:31];
   assign e_blue   = mem_q_ff[30:23];
   assign e_delta  = mem_q_ff[22:15];
   assign e_hue    = mem_q_ff[14:0];
   assign e_chroma = (e_delta != 8'd0) && (e_delta >= achrom_ff);
   assign use_hue  = mode_ff && pix_chroma_ff && e_chroma;

   always_comb begin
      manh = 10'(red_ff > e_red ? red_ff - e_red : e_red - red_ff)
           + 10'(green_ff > e_green ? green_ff - e_green : e_green - green_ff)
           + 10'(blue_ff > e_blue ? blue_ff - e_blue : e_blue - blue_ff);
      hd = (pix_hue_ff > e_hue) ? (pix_hue_ff - e_hue) : (e_hue - pix_hue_ff);
      if (hd > HUE_HALF) hd = HUE_FULL[14:0] - hd;
      scan_dist = use_hue ? 10'(hd >> 6) : manh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
         dv_ff <= 1'b0;
      end else begin
         rv_ff <= rd_issue;
         dv_ff <= rv_ff;
      end
   end

   always_ff @(posedge clock) begin
      ridx_ff <= cnt_ff[IDX_W-1:0];
      if (rv_ff) begin
         didx_ff <= ridx_ff;
         dist_ff <= scan_dist;
         den_ff  <= e_en;
      end
      if (state_ff == ST_HUE) begin
         found_ff     <= 1'b0;
         best_idx_ff  <= '0;
         best_dist_ff <= '0;
      end else if (dv_ff && den_ff && (dist_ff <= tolerance_ff)
                   && (!found_ff || (dist_ff < best_dist_ff))) begin
         found_ff     <= 1'b1;
         best_idx_ff  <= didx_ff;
         best_dist_ff <= dist_ff;
      end
   end

   assign rsp_match_found    = found_ff;
   assign rsp_match_index    = 6'(best_idx_ff);
   assign rsp_match_distance = best_dist_ff;

   `NPCM_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)
   `NPCM_ASSERT_NOW(a_empty_result, clock, reset, rsp_valid && !rsp_match_found,
                    rsp_match_index == 6'd0 && rsp_match_distance == 10'd0)
   `NPCM_ASSERT_NOW(a_within_tol, clock, reset, rsp_valid && rsp_match_found,
                    rsp_match_distance <= tolerance_ff)
   `NPCM_ASSERT_NOW(a_hue_in_phase, clock, reset, hue_res.done, state_ff == ST_HUE)

endmodule
